// ----- sv/bids_pkg.sv -----
// Shared types, constants and register codes for the bilinear downscaler.
// No dependencies; every other file refers to it by scoped names.
package bids_pkg;

   localparam int CH_W          = 8;
   localparam int NUM_CH        = 3;
   localparam int PIX_W         = CH_W * NUM_CH;
   localparam int CNT_W         = 11;
   localparam int DIM_W         = 12;
   localparam int STEP_REG_W    = 14;
   localparam int MAX_DIM       = 2048;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int FRAC_BITS_DEF = 12;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_W  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_H  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_W  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_H  = 3'd4;

   localparam logic [DIM_W-1:0]      RST_SRC_W = 12'd640;
   localparam logic [DIM_W-1:0]      RST_SRC_H = 12'd480;
   localparam logic [STEP_REG_W-1:0] RST_STEP  = 14'd5851;
   localparam logic [DIM_W-1:0]      RST_OUT_W = 12'd448;
   localparam logic [DIM_W-1:0]      RST_OUT_H = 12'd336;

   typedef logic [NUM_CH-1:0][CH_W-1:0] pix_type;

   typedef struct packed {
      pix_type tl;
      pix_type tr;
      pix_type bl;
      pix_type br;
   } pix_quad_type;

   typedef struct packed {
      logic h_en;
      logic v_en;
   } blend_ctrl_type;

   typedef struct packed {
      logic [DIM_W-1:0]      src_w;
      logic [DIM_W-1:0]      src_h;
      logic [DIM_W-1:0]      out_w;
      logic [DIM_W-1:0]      out_h;
      logic [STEP_REG_W-1:0] step;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_PICK,
      ST_HORIZ,
      ST_VERT,
      ST_SUM,
      ST_FINISH
   } state_type;

endpackage

// ----- sv/bilinear_image_downscaler.sv -----
// Top level of the streaming bilinear downscaler: sequencer, counters, output register.
// Instantiates bids_csr, bids_line_buf and bids_blend; uses bids_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_chan0_in, req_chan1_in, req_chan2_in
//   rsp      out        rsp_valid / rsp_ready  rsp_chan0..2_out, rsp_out_row, rsp_out_col,
//                                              rsp_run_last
//   csr      in/out     psel, penable, pready  paddr, pwrite, pwdata, prdata
//
// An item causes 0 to 4 results. Every item goes through the line buffer read,
// position planning and write-back; each result goes through the two-stage
// blend unit and the rounding add.
// The last result may wait in the output register while the next item is accepted.
// Synchronous reset clears counters, positions and the sequencer; the line buffer
// is not cleared. rsp_ready low holds the output register, and holds the sequencer in its sum state.
module bilinear_image_downscaler #(
   parameter int MAX_WIDTH = bids_pkg::MAX_WIDTH_DEF,
   parameter int FRAC_BITS = bids_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bids_pkg::CH_W-1:0]       req_chan0_in,
   input  logic [bids_pkg::CH_W-1:0]       req_chan1_in,
   input  logic [bids_pkg::CH_W-1:0]       req_chan2_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bids_pkg::CH_W-1:0]       rsp_chan0_out,
   output logic [bids_pkg::CH_W-1:0]       rsp_chan1_out,
   output logic [bids_pkg::CH_W-1:0]       rsp_chan2_out,
   output logic [bids_pkg::CNT_W-1:0]      rsp_out_row,
   output logic [bids_pkg::CNT_W-1:0]      rsp_out_col,
   output logic                            rsp_run_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bids_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bids_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bids_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int CNT_W     = bids_pkg::CNT_W;
   localparam int DIM_W     = bids_pkg::DIM_W;
   localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int POS_W     = CNT_W + FRAC_BITS;
   localparam int STEP_W    = (FRAC_BITS + 1 > bids_pkg::STEP_REG_W) ?
                              FRAC_BITS + 1 : bids_pkg::STEP_REG_W;
   localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
   localparam logic [STEP_W-1:0] UNIT      = STEP_W'(1) << FRAC_BITS;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_WIDTH - 1);

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0]  p,
                                                input logic [STEP_W-1:0] s);
      logic [POS_W:0] q;
      q = {1'b0, p} + (POS_W + 1)'(s);
      if (p == POS_MAX || q >= {1'b0, POS_MAX}) begin
         return POS_MAX;
      end
      return q[POS_W-1:0];
   endfunction

   // returns {hit, uses previous line}
   function automatic logic [1:0] hits(input logic [POS_W-1:0] p,
                                       input logic [CNT_W-1:0] line,
                                       input logic             last);
      logic [CNT_W-1:0] fl;
      fl = p[POS_W-1 -: CNT_W];
      if (p == POS_MAX) begin
         return 2'b00;
      end else if (line != '0 && fl == line - CNT_W'(1)) begin
         return 2'b11;
      end else if (last && fl == line) begin
         return 2'b10;
      end
      return 2'b00;
   endfunction

   function automatic logic [1:0] count(input logic [CNT_W-1:0] k,
                                        input logic [DIM_W-1:0] n,
                                        input logic             h0,
                                        input logic             h1);
      if ({1'b0, k} >= n || !h0) begin
         return 2'd0;
      end else if ({1'b0, k} + DIM_W'(1) < n && h1) begin
         return 2'd2;
      end
      return 2'd1;
   endfunction

   // returns {next index, next position}
   function automatic logic [CNT_W+POS_W-1:0] adv(input logic [CNT_W-1:0] k,
                                                  input logic [POS_W-1:0] p,
                                                  input logic [POS_W-1:0] p2,
                                                  input logic [POS_W-1:0] p3,
                                                  input logic [1:0]       cnt,
                                                  input logic [DIM_W-1:0] n);
      logic [DIM_W-1:0] k1, k2;
      k1 = {1'b0, k} + DIM_W'(1);
      k2 = {1'b0, k} + DIM_W'(2);
      case (cnt)
         2'd1:    return (k1 < n) ? {k1[CNT_W-1:0], p2} : {k, POS_MAX};
         2'd2:    return (k2 < n) ? {k2[CNT_W-1:0], p3} : {k1[CNT_W-1:0], POS_MAX};
         default: return {k, p};
      endcase
   endfunction

   bids_pkg::cfg_type        cfg;
   bids_pkg::state_type      state_ff, state_in;
   bids_pkg::blend_ctrl_type blend_ctrl;
   bids_pkg::pix_quad_type   quad;
   bids_pkg::pix_type        up, px_ff, px_in, lcur_ff, lcur_in, lprev_ff, lprev_in;
   bids_pkg::pix_type        blend_res, rsp_pix_ff, rsp_pix_in;

   logic [CNT_W-1:0]  col_cnt_ff, col_cnt_in, row_cnt_ff, row_cnt_in;
   logic [CNT_W-1:0]  ocol_ff, ocol_in, orow_ff, orow_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [POS_W-1:0]  cpos_ff, cpos_in, rpos_ff, rpos_in;
   logic [POS_W-1:0]  cp2_ff, cp2_in, rp2_ff, rp2_in, cp3_ff, cp3_in, rp3_ff, rp3_in;
   logic [1:0]        nc_ff, nc_in, nr_ff, nr_in, cprev_ff, cprev_in, rprev_ff, rprev_in;
   logic              a_ff, a_in, b_ff, b_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;

   logic [STEP_W-1:0]      step;
   logic                   last_col, last_row, accept, rd_en, wr_en, top_sel, left_sel;
   logic                   out_free, more_cols;
   logic [1:0]             hc0, hc1, hr0, hr1, nc_calc, nr_calc;
   logic [POS_W-1:0]       upos, vpos;
   logic [CNT_W+POS_W-1:0] col_adv, row_adv;

   assign pready    = 1'b1;
   assign req_ready = (state_ff == bids_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rd_en     = accept;
   assign px_in     = {req_chan2_in, req_chan1_in, req_chan0_in};

   bids_csr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   bids_line_buf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (up),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (px_ff)
   );

   bids_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock  (clock),
      .ctrl   (blend_ctrl),
      .quad   (quad),
      .u      (upos[FRAC_BITS-1:0]),
      .v      (vpos[FRAC_BITS-1:0]),
      .result (blend_res)
   );

   always_comb begin
      step     = (STEP_W'(cfg.step) < UNIT) ? UNIT : STEP_W'(cfg.step);
      last_col = ({1'b0, col_cnt_ff} + DIM_W'(1)) >= cfg.src_w;
      last_row = ({1'b0, row_cnt_ff} + DIM_W'(1)) >= cfg.src_h;

      hc0      = hits(cpos_ff, col_cnt_ff, last_col);
      hc1      = hits(cp2_ff, col_cnt_ff, last_col);
      hr0      = hits(rpos_ff, row_cnt_ff, last_row);
      hr1      = hits(rp2_ff, row_cnt_ff, last_row);
      nc_calc  = count(ocol_ff, cfg.out_w, hc0[1], hc1[1]);
      nr_calc  = count(orow_ff, cfg.out_h, hr0[1], hr1[1]);
      col_adv  = adv(ocol_ff, cpos_ff, cp2_ff, cp3_ff, nc_ff, cfg.out_w);
      row_adv  = adv(orow_ff, rpos_ff, rp2_ff, rp3_ff, nr_ff, cfg.out_h);

      top_sel  = rprev_ff[a_ff];
      left_sel = cprev_ff[b_ff];
      upos     = a_ff ? rp2_ff : rpos_ff;
      vpos     = b_ff ? cp2_ff : cpos_ff;
      quad.tl  = top_sel ? (left_sel ? lprev_ff : up) : (left_sel ? lcur_ff : px_ff);
      quad.tr  = top_sel ? up : px_ff;
      quad.bl  = left_sel ? lcur_ff : px_ff;
      quad.br  = px_ff;

      out_free  = !rsp_valid_ff || rsp_ready;
      more_cols = (nc_ff == 2'd2) && !b_ff;
   end

   always_comb begin
      state_in     = state_ff;
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      addr_in      = addr_ff;
      cpos_in      = cpos_ff;
      rpos_in      = rpos_ff;
      cp2_in       = cp2_ff;
      rp2_in       = rp2_ff;
      cp3_in       = cp3_ff;
      rp3_in       = rp3_ff;
      nc_in        = nc_ff;
      nr_in        = nr_ff;
      cprev_in     = cprev_ff;
      rprev_in     = rprev_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      lcur_in      = lcur_ff;
      lprev_in     = lprev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      blend_ctrl   = '0;

      case (state_ff)
         bids_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bids_pkg::ST_PLAN;
            end
         end
         bids_pkg::ST_PLAN: begin
            wr_en    = 1'b1;
            cp2_in   = sat_add(cpos_ff, step);
            rp2_in   = sat_add(rpos_ff, step);
            state_in = bids_pkg::ST_PICK;
         end
         bids_pkg::ST_PICK: begin
            nc_in    = nc_calc;
            nr_in    = nr_calc;
            cprev_in = {hc1[0], hc0[0]};
            rprev_in = {hr1[0], hr0[0]};
            cp3_in   = sat_add(cp2_ff, step);
            rp3_in   = sat_add(rp2_ff, step);
            a_in     = 1'b0;
            b_in     = 1'b0;
            state_in = (nc_calc != 2'd0 && nr_calc != 2'd0) ?
                       bids_pkg::ST_HORIZ : bids_pkg::ST_FINISH;
         end
         bids_pkg::ST_HORIZ: begin
            blend_ctrl.h_en = 1'b1;
            state_in        = bids_pkg::ST_VERT;
         end
         bids_pkg::ST_VERT: begin
            blend_ctrl.v_en = 1'b1;
            state_in        = bids_pkg::ST_SUM;
         end
         bids_pkg::ST_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = blend_res;
               rsp_row_in   = orow_ff + CNT_W'(a_ff);
               rsp_col_in   = ocol_ff + CNT_W'(b_ff);
               rsp_last_in  = !more_cols && !((nr_ff == 2'd2) && !a_ff);
               if (more_cols) begin
                  b_in     = 1'b1;
                  state_in = bids_pkg::ST_HORIZ;
               end else if ((nr_ff == 2'd2) && !a_ff) begin
                  a_in     = 1'b1;
                  b_in     = 1'b0;
                  state_in = bids_pkg::ST_HORIZ;
               end else begin
                  state_in = bids_pkg::ST_FINISH;
               end
            end
         end
         bids_pkg::ST_FINISH: begin
            lprev_in = up;
            lcur_in  = px_ff;
            if (last_col) begin
               col_cnt_in = '0;
               ocol_in    = '0;
               cpos_in    = '0;
               addr_in    = '0;
               if (last_row) begin
                  row_cnt_in = '0;
                  orow_in    = '0;
                  rpos_in    = '0;
               end else begin
                  row_cnt_in = row_cnt_ff + CNT_W'(1);
                  {orow_in, rpos_in} = row_adv;
               end
            end else begin
               col_cnt_in = col_cnt_ff + CNT_W'(1);
               {ocol_in, cpos_in} = col_adv;
               addr_in    = (addr_ff == ADDR_LAST || col_cnt_ff == '1) ?
                            '0 : addr_ff + ADDR_W'(1);
            end
            state_in = bids_pkg::ST_IDLE;
         end
         default: begin
            state_in = bids_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bids_pkg::ST_IDLE;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         addr_ff      <= '0;
         cpos_ff      <= '0;
         rpos_ff      <= '0;
         lcur_ff      <= '0;
         lprev_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         addr_ff      <= addr_in;
         cpos_ff      <= cpos_in;
         rpos_ff      <= rpos_in;
         lcur_ff      <= lcur_in;
         lprev_ff     <= lprev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= px_in;
      end
      cp2_ff      <= cp2_in;
      rp2_ff      <= rp2_in;
      cp3_ff      <= cp3_in;
      rp3_ff      <= rp3_in;
      nc_ff       <= nc_in;
      nr_ff       <= nr_in;
      cprev_ff    <= cprev_in;
      rprev_ff    <= rprev_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_chan0_out = rsp_pix_ff[0];
   assign rsp_chan1_out = rsp_pix_ff[1];
   assign rsp_chan2_out = rsp_pix_ff[2];
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_run_last  = rsp_last_ff;

endmodule

// ----- sv/bids_csr.sv -----
// Configuration registers behind the APB-style port, with clamped views.
// Depends on bids_pkg.
module bids_csr #(
   parameter int MAX_WIDTH = bids_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bids_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bids_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bids_pkg::CSR_DATA_W-1:0]     prdata,
   output bids_pkg::cfg_type                   cfg
);

   logic [bids_pkg::DIM_W-1:0]      src_w_ff, src_h_ff, out_w_ff, out_h_ff;
   logic [bids_pkg::STEP_REG_W-1:0] step_ff;
   logic [bids_pkg::CSR_IDX_W-1:0]  idx;
   logic                            wr;

   assign idx = paddr[bids_pkg::CSR_ADDR_W-1:2];
   assign wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= bids_pkg::RST_SRC_W;
         src_h_ff <= bids_pkg::RST_SRC_H;
         step_ff  <= bids_pkg::RST_STEP;
         out_w_ff <= bids_pkg::RST_OUT_W;
         out_h_ff <= bids_pkg::RST_OUT_H;
      end else if (wr) begin
         case (idx)
            bids_pkg::REG_SRC_W: src_w_ff <= pwdata[bids_pkg::DIM_W-1:0];
            bids_pkg::REG_SRC_H: src_h_ff <= pwdata[bids_pkg::DIM_W-1:0];
            bids_pkg::REG_STEP:  step_ff  <= pwdata[bids_pkg::STEP_REG_W-1:0];
            bids_pkg::REG_OUT_W: out_w_ff <= pwdata[bids_pkg::DIM_W-1:0];
            bids_pkg::REG_OUT_H: out_h_ff <= pwdata[bids_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         bids_pkg::REG_SRC_W: prdata = bids_pkg::CSR_DATA_W'(src_w_ff);
         bids_pkg::REG_SRC_H: prdata = bids_pkg::CSR_DATA_W'(src_h_ff);
         bids_pkg::REG_STEP:  prdata = bids_pkg::CSR_DATA_W'(step_ff);
         bids_pkg::REG_OUT_W: prdata = bids_pkg::CSR_DATA_W'(out_w_ff);
         bids_pkg::REG_OUT_H: prdata = bids_pkg::CSR_DATA_W'(out_h_ff);
         default:             prdata = '0;
      endcase
   end

   always_comb begin
      if (src_w_ff == '0) begin
         cfg.src_w = bids_pkg::DIM_W'(1);
      end else if (32'(src_w_ff) > 32'(MAX_WIDTH)) begin
         cfg.src_w = bids_pkg::DIM_W'(MAX_WIDTH);
      end else begin
         cfg.src_w = src_w_ff;
      end
      if (src_h_ff == '0) begin
         cfg.src_h = bids_pkg::DIM_W'(1);
      end else if (32'(src_h_ff) > 32'(bids_pkg::MAX_DIM)) begin
         cfg.src_h = bids_pkg::DIM_W'(bids_pkg::MAX_DIM);
      end else begin
         cfg.src_h = src_h_ff;
      end
      cfg.out_w = (32'(out_w_ff) > 32'(bids_pkg::MAX_DIM)) ?
                  bids_pkg::DIM_W'(bids_pkg::MAX_DIM) : out_w_ff;
      cfg.out_h = (32'(out_h_ff) > 32'(bids_pkg::MAX_DIM)) ?
                  bids_pkg::DIM_W'(bids_pkg::MAX_DIM) : out_h_ff;
      cfg.step  = step_ff;
   end

endmodule

// ----- sv/bids_line_buf.sv -----
// Line buffer: one row of source pixels, one write and one read port.
// Read data is registered. Depends on bids_pkg.
module bids_line_buf #(
   parameter int DEPTH  = bids_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output bids_pkg::pix_type rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  bids_pkg::pix_type wr_data
);

   bids_pkg::pix_type mem_q [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_q[rd_addr];
      end
   end

endmodule

// ----- sv/bids_blend.sv -----
// Two-stage bilinear blend of four neighbor pixels, three channel lanes.
// Horizontal pass, then vertical pass; rounding add is combinational. Uses bids_pkg.
module bids_blend #(
   parameter int FRAC_BITS = bids_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  bids_pkg::blend_ctrl_type ctrl,
   input  bids_pkg::pix_quad_type quad,
   input  logic [FRAC_BITS-1:0]   u,
   input  logic [FRAC_BITS-1:0]   v,
   output bids_pkg::pix_type      result
);

   localparam int W_W = FRAC_BITS + 1;
   localparam int H_W = FRAC_BITS + bids_pkg::CH_W;
   localparam int P_W = 2 * FRAC_BITS + bids_pkg::CH_W;
   localparam logic [W_W-1:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [P_W-1:0] HALF = P_W'(1) << (2 * FRAC_BITS - 1);

   logic [bids_pkg::NUM_CH-1:0][H_W-1:0] top_ff, top_in, bot_ff, bot_in;
   logic [bids_pkg::NUM_CH-1:0][P_W-1:0] pa_ff, pa_in, pb_ff, pb_in, sum;
   logic [W_W-1:0]                       wu, wv;

   always_comb begin
      wu = UNIT - {1'b0, u};
      wv = UNIT - {1'b0, v};
      for (int ch = 0; ch < bids_pkg::NUM_CH; ch++) begin
         top_in[ch] = H_W'(wv) * H_W'(quad.tl[ch]) + H_W'(v) * H_W'(quad.tr[ch]);
         bot_in[ch] = H_W'(wv) * H_W'(quad.bl[ch]) + H_W'(v) * H_W'(quad.br[ch]);
         pa_in[ch]  = P_W'(wu) * P_W'(top_ff[ch]);
         pb_in[ch]  = P_W'(u) * P_W'(bot_ff[ch]);
         sum[ch]    = pa_ff[ch] + pb_ff[ch] + HALF;
         result[ch] = sum[ch][2*FRAC_BITS +: bids_pkg::CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.h_en) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
      end
      if (ctrl.v_en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

endmodule

// ----- sv/bids_checker.sv -----
// Port-level checks for the bilinear downscaler, bound to the top level.
// Depends on bids_pkg and bilinear_image_downscaler.
module bids_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bids_pkg::CH_W-1:0]  rsp_chan0_out,
   input logic [bids_pkg::CH_W-1:0]  rsp_chan1_out,
   input logic [bids_pkg::CH_W-1:0]  rsp_chan2_out,
   input logic [bids_pkg::CNT_W-1:0] rsp_out_row,
   input logic [bids_pkg::CNT_W-1:0] rsp_out_col,
   input logic                       rsp_run_last
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_chan0_out)
         && $stable(rsp_chan1_out) && $stable(rsp_chan2_out)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_run_last)))
      else $error("stalled result item changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again right after an accepted item");

   a_run_in_flight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=> !req_ready)
      else $error("input item accepted before its run of results ended");

endmodule

bind bilinear_image_downscaler bids_checker u_bids_checker (.*);
